// ===== design/lrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared types, command codes and rotation tables of the rectangle fill
// command generator.
// ----------------------------------------------------------------------------
package lrf_pkg;

    // Default visible panel size before rotation
    localparam int unsigned PANEL_WIDTH_DEF  = 135;
    localparam int unsigned PANEL_HEIGHT_DEF = 240;

    // Field widths
    localparam int unsigned COORD_W = 16;
    localparam int unsigned COUNT_W = 15;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned ROT_W   = 2;

    // Largest burst count; larger products saturate here
    localparam logic [COUNT_W-1:0] BURST_MAX = '1;

    // Depth of the job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_CMD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BURST = 2'd2;

    // Display controller commands
    localparam logic [7:0] CMD_COLUMN_ADDR  = 8'h2A;
    localparam logic [7:0] CMD_ROW_ADDR     = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

    // One clipped request, ready to be sent
    typedef struct packed {
        logic [COORD_W-1:0] col_start;
        logic [COORD_W-1:0] col_end;
        logic [COORD_W-1:0] row_start;
        logic [COORD_W-1:0] row_end;
        logic [15:0]        color;
        logic [COUNT_W-1:0] count;
    } t_job;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_status;

    // Column offset for a rotation
    function automatic logic [COORD_W-1:0] col_offset(input logic [ROT_W-1:0] rot);
        logic [COORD_W-1:0] ofs;
        case (rot)
            2'd0:    ofs = 16'd52;
            2'd1:    ofs = 16'd40;
            2'd2:    ofs = 16'd53;
            2'd3:    ofs = 16'd40;
            default: ofs = 16'd52;
        endcase
        return ofs;
    endfunction

    // Row offset for a rotation
    function automatic logic [COORD_W-1:0] row_offset(input logic [ROT_W-1:0] rot);
        logic [COORD_W-1:0] ofs;
        case (rot)
            2'd0:    ofs = 16'd40;
            2'd1:    ofs = 16'd53;
            2'd2:    ofs = 16'd40;
            2'd3:    ofs = 16'd52;
            default: ofs = 16'd40;
        endcase
        return ofs;
    endfunction

endpackage

// ===== design/lrf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_req_if / lrf_item_if
// Valid/ready channels for fill requests and for the generated items.
// ----------------------------------------------------------------------------
interface lrf_req_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic        [15:0] fill_color;

    modport source (output valid, rect_x, rect_y, rect_w, rect_h, fill_color,
                    input ready);
    modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, fill_color,
                    output ready);
endinterface

interface lrf_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [15:0] item_value;
    logic [14:0] burst_count;
    logic        last_item;

    modport source (output valid, item_kind, item_value, burst_count, last_item,
                    input ready);
    modport sink   (input valid, item_kind, item_value, burst_count, last_item,
                    output ready);
endinterface

// ===== design/lrf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_front
// Accepts fill requests, clips them to the rotated panel, drops empty ones
// and pushes the address window, colour and pixel count into the job queue.
// ----------------------------------------------------------------------------
module lrf_front #(
    parameter int unsigned PANEL_WIDTH  = lrf_pkg::PANEL_WIDTH_DEF,
    parameter int unsigned PANEL_HEIGHT = lrf_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lrf_pkg::ROT_W-1:0]  i_cfg_wdata,
    lrf_req_if.sink                    i_req,
    input  lrf_pkg::t_q_status         i_q_status,
    output logic                       o_push,
    output lrf_pkg::t_job              o_job
);
    import lrf_pkg::*;

    localparam int unsigned DIM_MAX = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH
                                                                   : PANEL_HEIGHT;
    localparam int unsigned DIM_W   = $clog2(DIM_MAX + 1);
    localparam int unsigned PROD_W  = 2 * DIM_W;
    localparam int unsigned EXT_W   = 18;

    localparam logic signed [EXT_W-1:0] WIDTH_S  = EXT_W'(PANEL_WIDTH);
    localparam logic signed [EXT_W-1:0] HEIGHT_S = EXT_W'(PANEL_HEIGHT);

    logic [ROT_W-1:0]        r_rot;
    logic                    r_s1_valid;
    logic [DIM_W-1:0]        r_x;
    logic [DIM_W-1:0]        r_y;
    logic [DIM_W-1:0]        r_w;
    logic [DIM_W-1:0]        r_h;
    logic [15:0]             r_color;

    logic signed [EXT_W-1:0] x_s, y_s, w_s, h_s;
    logic signed [EXT_W-1:0] lim_w, lim_h;
    logic signed [EXT_W-1:0] xc, yc, wc, hc;
    logic                    off_panel;
    logic                    keep;
    logic                    accept;
    logic                    s1_go;
    logic [DIM_W:0]          col_last;
    logic [DIM_W:0]          row_last;
    logic [PROD_W-1:0]       prod;

    // Hold the rotation register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot <= '0;
        end else if (i_cfg_we) begin
            r_rot <= i_cfg_wdata;
        end
    end

    // Clip the incoming rectangle against the rotated visible area
    always_comb begin
        x_s   = EXT_W'(i_req.rect_x);
        y_s   = EXT_W'(i_req.rect_y);
        w_s   = EXT_W'(i_req.rect_w);
        h_s   = EXT_W'(i_req.rect_h);
        lim_w = r_rot[0] ? HEIGHT_S : WIDTH_S;
        lim_h = r_rot[0] ? WIDTH_S  : HEIGHT_S;

        off_panel = (x_s >= lim_w) || (y_s >= lim_h);

        xc = (x_s < 0) ? '0 : x_s;
        wc = (x_s < 0) ? (w_s + x_s) : w_s;
        yc = (y_s < 0) ? '0 : y_s;
        hc = (y_s < 0) ? (h_s + y_s) : h_s;

        if ((xc + wc) > lim_w) begin
            wc = lim_w - xc;
        end
        if ((yc + hc) > lim_h) begin
            hc = lim_h - yc;
        end

        keep = !off_panel && (wc >= 1) && (hc >= 1);
    end

    // Advance the clipped stage into the queue when there is room
    assign s1_go       = r_s1_valid && !i_q_status.full;
    assign i_req.ready = !r_s1_valid || !i_q_status.full;
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= keep;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Capture clipped geometry; empty requests never become valid
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x     <= xc[DIM_W-1:0];
            r_y     <= yc[DIM_W-1:0];
            r_w     <= wc[DIM_W-1:0];
            r_h     <= hc[DIM_W-1:0];
            r_color <= i_req.fill_color;
        end
    end

    // Build the job: window ends with offsets, saturated pixel count
    always_comb begin
        col_last = {1'b0, r_x} + {1'b0, r_w} - (DIM_W+1)'(1);
        row_last = {1'b0, r_y} + {1'b0, r_h} - (DIM_W+1)'(1);
        prod     = PROD_W'(r_w) * PROD_W'(r_h);

        o_job.col_start = COORD_W'(r_x) + col_offset(r_rot);
        o_job.col_end   = COORD_W'(col_last) + col_offset(r_rot);
        o_job.row_start = COORD_W'(r_y) + row_offset(r_rot);
        o_job.row_end   = COORD_W'(row_last) + row_offset(r_rot);
        o_job.color     = r_color;
        if (32'(prod) > 32'(BURST_MAX)) begin
            o_job.count = BURST_MAX;
        end else begin
            o_job.count = COUNT_W'(prod);
        end
    end

    assign o_push = s1_go;

endmodule

// ===== design/lrf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_queue
// Short job queue that decouples request clipping from item sequencing.
// ----------------------------------------------------------------------------
module lrf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lrf_pkg::t_job       i_job,
    input  logic                i_pop,
    output lrf_pkg::t_job       o_head,
    output lrf_pkg::t_q_status  o_status
);
    import lrf_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.nonempty = (r_count != '0);
    assign do_push           = i_push && !o_status.full;
    assign do_pop            = i_pop && o_status.nonempty;
    assign o_head            = r_slot[r_rd_ptr];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and track the fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/lrf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_back
// Walks each queued job through the twelve output items: window commands,
// coordinate bytes, memory write and the pixel burst.
// ----------------------------------------------------------------------------
module lrf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lrf_pkg::t_job       i_head,
    input  lrf_pkg::t_q_status  i_q_status,
    output logic                o_pop,
    lrf_item_if.source          o_item
);
    import lrf_pkg::*;

    // Sequencer steps
    localparam logic [3:0] STEP_CASET    = 4'd0;
    localparam logic [3:0] STEP_XS_HI    = 4'd1;
    localparam logic [3:0] STEP_XS_LO    = 4'd2;
    localparam logic [3:0] STEP_XE_HI    = 4'd3;
    localparam logic [3:0] STEP_XE_LO    = 4'd4;
    localparam logic [3:0] STEP_RASET    = 4'd5;
    localparam logic [3:0] STEP_YS_HI    = 4'd6;
    localparam logic [3:0] STEP_YS_LO    = 4'd7;
    localparam logic [3:0] STEP_YE_HI    = 4'd8;
    localparam logic [3:0] STEP_YE_LO    = 4'd9;
    localparam logic [3:0] STEP_RAMWR    = 4'd10;
    localparam logic [3:0] STEP_BURST    = 4'd11;

    logic [3:0]         r_step;
    logic [3:0]         n_step;
    logic               r_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [15:0]        r_value;
    logic [COUNT_W-1:0] r_count;
    logic               r_last;

    logic               load;
    logic [KIND_W-1:0]  n_kind;
    logic [15:0]        n_value;
    logic [COUNT_W-1:0] n_count;
    logic               n_last;

    // Produce the next item when the output register frees up
    assign load  = i_q_status.nonempty && (!r_valid || o_item.ready);
    assign o_pop = load && (r_step == STEP_BURST);

    // Select the item for the current step
    always_comb begin
        n_kind  = KIND_DATA;
        n_value = '0;
        n_count = '0;
        n_last  = 1'b0;
        n_step  = r_step + 1'b1;
        case (r_step)
            STEP_CASET: begin
                n_kind  = KIND_CMD;
                n_value = {8'h00, CMD_COLUMN_ADDR};
            end
            STEP_XS_HI: n_value = {8'h00, i_head.col_start[15:8]};
            STEP_XS_LO: n_value = {8'h00, i_head.col_start[7:0]};
            STEP_XE_HI: n_value = {8'h00, i_head.col_end[15:8]};
            STEP_XE_LO: n_value = {8'h00, i_head.col_end[7:0]};
            STEP_RASET: begin
                n_kind  = KIND_CMD;
                n_value = {8'h00, CMD_ROW_ADDR};
            end
            STEP_YS_HI: n_value = {8'h00, i_head.row_start[15:8]};
            STEP_YS_LO: n_value = {8'h00, i_head.row_start[7:0]};
            STEP_YE_HI: n_value = {8'h00, i_head.row_end[15:8]};
            STEP_YE_LO: n_value = {8'h00, i_head.row_end[7:0]};
            STEP_RAMWR: begin
                n_kind  = KIND_CMD;
                n_value = {8'h00, CMD_MEMORY_WRITE};
            end
            STEP_BURST: begin
                n_kind  = KIND_BURST;
                n_value = i_head.color;
                n_count = i_head.count;
                n_last  = 1'b1;
                n_step  = STEP_CASET;
            end
            default: begin
                n_step  = STEP_CASET;
            end
        endcase
    end

    // Hold the step and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_CASET;
            r_valid <= 1'b0;
        end else if (load) begin
            r_step  <= n_step;
            r_valid <= 1'b1;
        end else if (o_item.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the item payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_count <= n_count;
            r_last  <= n_last;
        end
    end

    assign o_item.valid       = r_valid;
    assign o_item.item_kind   = r_kind;
    assign o_item.item_value  = r_value;
    assign o_item.burst_count = r_count;
    assign o_item.last_item   = r_last;

endmodule

// ===== design/lcd_rect_fill_command_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_rect_fill_command_generator_top
// Clips fill-rectangle requests to the rotated panel and turns each into the
// address window command sequence followed by one pixel burst.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  i_req     in         rect_x, rect_y, rect_w, rect_h, fill_color
//  o_item    out        item_kind, item_value, burst_count, last_item
//  i_cfg_*   in         rotation (write only)
//
//  A request that survives clipping yields twelve items, one per cycle
//  while the output is ready, issued by the item sequencer; requests
//  clipped away yield nothing. An accepted request passes the clipping
//  register and the job queue before its first item is registered.
//  A two-entry job queue lets requests be taken while items are stalled.
//  Reset is synchronous; rotation resets to 0 and no clearing pass is needed.
// ----------------------------------------------------------------------------
module lcd_rect_fill_command_generator_top #(
    parameter int unsigned PANEL_WIDTH  = lrf_pkg::PANEL_WIDTH_DEF,
    parameter int unsigned PANEL_HEIGHT = lrf_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lrf_pkg::ROT_W-1:0] i_cfg_wdata,
    lrf_req_if.sink                   i_req,
    lrf_item_if.source                o_item
);
    import lrf_pkg::*;

    t_job      job_in;
    t_job      job_head;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // Accept and clip requests
    lrf_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_job       (job_in)
    );

    // Buffer clipped jobs
    lrf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job_in),
        .i_pop    (pop),
        .o_head   (job_head),
        .o_status (q_status)
    );

    // Sequence the output items
    lrf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (job_head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_item     (o_item)
    );

endmodule
